// ===== rtl/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// pal_pkg
// Shared widths, codes, types and the power-on list contents for the
// positional array list engine.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int unsigned CAPACITY  = 16;
  localparam int unsigned IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);

  localparam int unsigned KIND_W    = 3;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned STAT_W    = 3;
  localparam int unsigned OIDX_W    = 4;
  localparam int unsigned OCNT_W    = 5;
  localparam int unsigned CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 48;

  localparam int unsigned INIT_LEN  = 10;
  localparam int unsigned INIT_CNT  = (CAPACITY < INIT_LEN) ? CAPACITY : INIT_LEN;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT  = 3'd0,
    KIND_UPDATE  = 3'd1,
    KIND_DELETE  = 3'd2,
    KIND_FIND    = 3'd3,
    KIND_DISPLAY = 3'd4
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT_UP,
    S_PUT,
    S_SHIFT_DN,
    S_SCAN,
    S_DISP,
    S_RESP
  } state_e;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    status_e           status;
    logic [OIDX_W-1:0] index;
    logic [VAL_W-1:0]  data;
    logic [OCNT_W-1:0] count;
    logic              last;
  } res_t;

  // power-on contents of the list, zero past the listed values
  function automatic logic [VAL_W-1:0] init_val(logic [IDX_W-1:0] idx);
    logic [VAL_W-1:0] v;
    case (32'(idx))
      0:       v = 32'd7;
      1:       v = 32'd21;
      2:       v = 32'd18;
      3:       v = 32'd45;
      4:       v = 32'd93;
      5:       v = 32'd3;
      6:       v = 32'd11;
      7:       v = 32'd1;
      8:       v = 32'd99;
      9:       v = 32'd17;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [OIDX_W-1:0] out_index(logic [IDX_W-1:0] i);
    logic [31:0] w;
    w = 32'(i);
    return w[OIDX_W-1:0];
  endfunction

  function automatic logic [OCNT_W-1:0] out_count(logic [CNT_W-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[OCNT_W-1:0];
  endfunction

endpackage

// ===== rtl/pal_mem.sv =====
// ----------------------------------------------------------------------------
// pal_mem
// Entry store: one write and one read port, registered read data. Entries
// never written read back their power-on value through per-entry valid bits.
// ----------------------------------------------------------------------------
module pal_mem (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pal_pkg::mem_req_t                req_i,
  output logic [pal_pkg::VAL_W-1:0]        rdata_o
);

  logic [pal_pkg::VAL_W-1:0]    mem_q [pal_pkg::CAPACITY];
  logic [pal_pkg::CAPACITY-1:0] vld_q;
  logic [pal_pkg::VAL_W-1:0]    rd_q;
  logic                         rvld_q;
  logic [pal_pkg::IDX_W-1:0]    ra_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rd_q <= mem_q[req_i.raddr];
    ra_q <= req_i.raddr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      rvld_q <= vld_q[req_i.raddr];
    end
  end

  assign rdata_o = rvld_q ? rd_q : pal_pkg::init_val(ra_q);

endmodule

// ===== rtl/pal_ctrl.sv =====
// ----------------------------------------------------------------------------
// pal_ctrl
// Command sequencer: decodes a command, walks the entry store one entry per
// cycle for shifts, search and readout (readout only while results are taken),
// and keeps the fill count.
module pal_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  logic [pal_pkg::KIND_W-1:0]    cmd_kind_i,
  input  logic [pal_pkg::POS_W-1:0]     cmd_pos_i,
  input  logic [pal_pkg::VAL_W-1:0]     cmd_val_i,
  output pal_pkg::mem_req_t             mem_req_o,
  input  logic [pal_pkg::VAL_W-1:0]     rdata_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output pal_pkg::res_t                 res_o
);

  localparam int unsigned IDX_W = pal_pkg::IDX_W;
  localparam int unsigned CNT_W = pal_pkg::CNT_W;
  localparam int unsigned CMP_W = pal_pkg::CMP_W;

  pal_pkg::state_e              state_q, state_d;
  logic [pal_pkg::KIND_W-1:0]   kind_q, kind_d;
  logic [pal_pkg::POS_W-1:0]    pos_q, pos_d;
  logic [pal_pkg::VAL_W-1:0]    key_q, key_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [CNT_W-1:0]             ptr_q, ptr_d;
  logic                         pend_q, pend_d;
  logic [IDX_W-1:0]             tag_q, tag_d;
  pal_pkg::status_e             st_q, st_d;
  logic [IDX_W-1:0]             idx_q, idx_d;

  logic [CMP_W-1:0] pos_x, cnt_x, ptr_x;
  logic [CNT_W:0]   ptr_inc;
  logic [CNT_W-1:0] ptr_dec;
  logic             is_full, is_empty, pos_le_cnt, pos_lt_cnt;
  logic             up_more, dn_more, scan_more, scan_hit, disp_last;

  assign pos_x      = CMP_W'(pos_q);
  assign cnt_x      = CMP_W'(cnt_q);
  assign ptr_x      = CMP_W'(ptr_q);
  assign ptr_inc    = {1'b0, ptr_q} + 1'b1;
  assign ptr_dec    = ptr_q - 1'b1;
  assign is_full    = (cnt_q == CNT_W'(pal_pkg::CAPACITY));
  assign is_empty   = (cnt_q == '0);
  assign pos_le_cnt = (pos_x <= cnt_x);
  assign pos_lt_cnt = (pos_x < cnt_x);
  assign up_more    = (ptr_x > pos_x);
  assign dn_more    = (ptr_inc < {1'b0, cnt_q});
  assign scan_more  = (ptr_q < cnt_q);
  assign scan_hit   = pend_q && (rdata_i == key_q);
  assign disp_last  = (ptr_inc == {1'b0, cnt_q});

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pal_pkg::S_IDLE: begin
        if (cmd_valid_i) state_d = pal_pkg::S_EXEC;
      end
      pal_pkg::S_EXEC: begin
        case (kind_q)
          pal_pkg::KIND_INSERT: begin
            if (is_full || !pos_le_cnt) state_d = pal_pkg::S_RESP;
            else                        state_d = pal_pkg::S_SHIFT_UP;
          end
          pal_pkg::KIND_DELETE: begin
            state_d = pos_lt_cnt ? pal_pkg::S_SHIFT_DN : pal_pkg::S_RESP;
          end
          pal_pkg::KIND_FIND:    state_d = pal_pkg::S_SCAN;
          pal_pkg::KIND_DISPLAY: begin
            state_d = is_empty ? pal_pkg::S_RESP : pal_pkg::S_DISP;
          end
          default:               state_d = pal_pkg::S_RESP;
        endcase
      end
      pal_pkg::S_SHIFT_UP: begin
        if (!up_more) state_d = pal_pkg::S_PUT;
      end
      pal_pkg::S_PUT:      state_d = pal_pkg::S_RESP;
      pal_pkg::S_SHIFT_DN: begin
        if (!dn_more) state_d = pal_pkg::S_RESP;
      end
      pal_pkg::S_SCAN: begin
        if (scan_hit || !scan_more) state_d = pal_pkg::S_RESP;
      end
      pal_pkg::S_DISP: begin
        if (res_ready_i && disp_last) state_d = pal_pkg::S_IDLE;
      end
      pal_pkg::S_RESP: begin
        if (res_ready_i) state_d = pal_pkg::S_IDLE;
      end
      default: state_d = pal_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_ready_o     = (state_q == pal_pkg::S_IDLE);
    kind_d          = kind_q;
    pos_d           = pos_q;
    key_d           = key_q;
    cnt_d           = cnt_q;
    ptr_d           = ptr_q;
    pend_d          = 1'b0;
    tag_d           = tag_q;
    st_d            = st_q;
    idx_d           = idx_q;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = tag_q;
    mem_req_o.wdata = rdata_i;
    mem_req_o.raddr = ptr_q[IDX_W-1:0];
    res_valid_o     = 1'b0;
    res_o.status    = st_q;
    res_o.index     = pal_pkg::out_index(idx_q);
    res_o.data      = '0;
    res_o.count     = pal_pkg::out_count(cnt_q);
    res_o.last      = 1'b1;

    case (state_q)
      pal_pkg::S_IDLE: begin
        if (cmd_valid_i) begin
          kind_d = cmd_kind_i;
          pos_d  = cmd_pos_i;
          key_d  = cmd_val_i;
          ptr_d  = '0;
        end
      end
      pal_pkg::S_EXEC: begin
        idx_d = '0;
        st_d  = pal_pkg::ST_OK;
        case (kind_q)
          pal_pkg::KIND_INSERT: begin
            if (is_full)          st_d  = pal_pkg::ST_FULL;
            else if (!pos_le_cnt) st_d  = pal_pkg::ST_INVALID;
            else                  ptr_d = cnt_q;
          end
          pal_pkg::KIND_UPDATE: begin
            if (pos_lt_cnt) begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = pos_x[IDX_W-1:0];
              mem_req_o.wdata = key_q;
            end else begin
              st_d = pal_pkg::ST_INVALID;
            end
          end
          pal_pkg::KIND_DELETE: begin
            if (pos_lt_cnt) ptr_d = pos_x[CNT_W-1:0];
            else            st_d  = pal_pkg::ST_INVALID;
          end
          pal_pkg::KIND_FIND: begin
            ptr_d = '0;
          end
          pal_pkg::KIND_DISPLAY: begin
            if (is_empty) st_d = pal_pkg::ST_EMPTY;
          end
          default: st_d = pal_pkg::ST_INVALID;
        endcase
      end
      pal_pkg::S_SHIFT_UP: begin
        // write back the entry read last cycle one slot higher
        mem_req_o.we = pend_q;
        if (up_more) begin
          mem_req_o.raddr = ptr_dec[IDX_W-1:0];
          pend_d          = 1'b1;
          tag_d           = ptr_q[IDX_W-1:0];
          ptr_d           = ptr_dec;
        end
      end
      pal_pkg::S_PUT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = pos_x[IDX_W-1:0];
        mem_req_o.wdata = key_q;
        cnt_d           = cnt_q + 1'b1;
        st_d            = pal_pkg::ST_OK;
      end
      pal_pkg::S_SHIFT_DN: begin
        mem_req_o.we = pend_q;
        if (dn_more) begin
          mem_req_o.raddr = ptr_inc[IDX_W-1:0];
          pend_d          = 1'b1;
          tag_d           = ptr_q[IDX_W-1:0];
          ptr_d           = ptr_inc[CNT_W-1:0];
        end else begin
          cnt_d = cnt_q - 1'b1;
          st_d  = pal_pkg::ST_OK;
        end
      end
      pal_pkg::S_SCAN: begin
        if (scan_hit) begin
          st_d  = pal_pkg::ST_OK;
          idx_d = tag_q;
        end else if (scan_more) begin
          pend_d = 1'b1;
          tag_d  = ptr_q[IDX_W-1:0];
          ptr_d  = ptr_inc[CNT_W-1:0];
        end else begin
          st_d  = pal_pkg::ST_NOTFOUND;
          idx_d = '0;
        end
      end
      pal_pkg::S_DISP: begin
        res_valid_o  = 1'b1;
        res_o.status = pal_pkg::ST_OK;
        res_o.index  = pal_pkg::out_index(ptr_q[IDX_W-1:0]);
        res_o.data   = rdata_i;
        res_o.last   = disp_last;
        // fetch the next entry as soon as this one is handed over
        if (res_ready_i && !disp_last) begin
          ptr_d           = ptr_inc[CNT_W-1:0];
          mem_req_o.raddr = ptr_inc[IDX_W-1:0];
        end
      end
      pal_pkg::S_RESP: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pal_pkg::S_IDLE;
      cnt_q   <= CNT_W'(pal_pkg::INIT_CNT);
      ptr_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    pos_q  <= pos_d;
    key_q  <= key_d;
    tag_q  <= tag_d;
    st_q   <= st_d;
    idx_q  <= idx_d;
  end

endmodule

// ===== rtl/pal_obuf.sv =====
// ----------------------------------------------------------------------------
// pal_obuf
// Result output register: holds one result for the downstream side and
// refills in the cycle it is taken.
// ----------------------------------------------------------------------------
module pal_obuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pal_pkg::res_t in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pal_pkg::res_t out_o
);

  logic          vld_q, vld_d;
  pal_pkg::res_t res_q;

  assign in_ready_o  = !vld_q || out_ready_i;
  assign vld_d       = (in_valid_i && in_ready_o) || (vld_q && !out_ready_i);
  assign out_valid_o = vld_q;
  assign out_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      res_q <= in_i;
    end
  end

endmodule

// ===== rtl/positional_array_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// positional_array_list_engine_top
// Packed list of signed 32-bit entries with insert, update, delete, find and
// full readout commands, kept in a single-port-write entry store.
//
//   channel   dir  tdata (low bit up)                    tuser    tlast
//   s_axis    in   position[4:0] value[36:5]              kind     -
//   m_axis    out  index[3:0] data[35:4] count[40:36]     status   last
//
// one command at a time; the entry store is walked one entry per cycle
// (readout only while results are taken)
// reset restores the initial list at once through per-entry valid bits
// a new command is taken while the last result still waits in the output
// ----------------------------------------------------------------------------
module positional_array_list_engine_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [pal_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // position, value
  input  logic [pal_pkg::KIND_W-1:0]      s_axis_tuser,  // kind
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [pal_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // index, data, count
  output logic [pal_pkg::STAT_W-1:0]      m_axis_tuser,  // status
  output logic                            m_axis_tlast
);

  pal_pkg::mem_req_t          mem_req;
  logic [pal_pkg::VAL_W-1:0]  rdata;
  logic                       res_valid;
  logic                       res_ready;
  pal_pkg::res_t              res;
  pal_pkg::res_t              out_res;

  pal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_o (s_axis_tready),
    .cmd_kind_i  (s_axis_tuser),
    .cmd_pos_i   (s_axis_tdata[4:0]),
    .cmd_val_i   (s_axis_tdata[36:5]),
    .mem_req_o   (mem_req),
    .rdata_i     (rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  pal_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  pal_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_ready_o  (res_ready),
    .in_i        (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out_res)
  );

  assign m_axis_tdata = {7'b0, out_res.count, out_res.data, out_res.index};
  assign m_axis_tuser = out_res.status;
  assign m_axis_tlast = out_res.last;

endmodule

// ===== rtl/pal_chk.sv =====
// ----------------------------------------------------------------------------
// pal_chk
// Port-level checks for the list engine, bound to the top level.
// ----------------------------------------------------------------------------
module pal_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [pal_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [pal_pkg::STAT_W-1:0]    m_axis_tuser,
  input logic                          m_axis_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // only one command in flight
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("command taken back to back");

  // only a readout gives several results, all of them ok
  a_mid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == pal_pkg::ST_OK)
    else $error("non-final result with error status");

  // fill count never exceeds the capacity
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 32'(m_axis_tdata[40:36]) <= pal_pkg::CAPACITY)
    else $error("fill count above capacity");

  // status codes stay within the defined set
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 32'(m_axis_tuser) <= 32'(pal_pkg::ST_EMPTY))
    else $error("undefined status code");

endmodule

bind positional_array_list_engine_top pal_chk u_pal_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== verif/tb_positional_array_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// tb_positional_array_list_engine_top
// Self-checking bench for the positional array list engine: commands go in on
// the slave stream, every result transaction on the master stream is checked
// field by field against a cycle-free list model kept inside the bench.
// ----------------------------------------------------------------------------
module tb_positional_array_list_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pal_pkg::*;

  localparam int unsigned N_ITEMS   = 410;
  localparam int unsigned TAIL_CYC  = 40;
  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [VAL_W-1:0] VAL_NEG1 = 32'hffff_ffff;
  localparam logic [KIND_W-1:0] KIND_TOP = KIND_W'((1 << KIND_W) - 1);
  localparam logic [POS_W-1:0] POS_TOP = POS_W'((1 << POS_W) - 1);

  localparam int MODE_GROW   = 0;
  localparam int MODE_SHRINK = 1;

  typedef struct packed {
    logic [CAPACITY-1:0][VAL_W-1:0] slot;
    logic [CNT_W-1:0]               fill;
  } array_list_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  value;
  } list_cmd_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [KIND_W-1:0]    s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0]    m_axis_tuser;
  logic                 m_axis_tlast;

  list_cmd_t   cmd_backlog[$];
  res_t        pending_results[$];
  res_t        step_results[$];
  res_t        plan_scratch[$];
  array_list_t model_list;
  array_list_t plan_list;

  list_cmd_t acc_cmd;
  list_cmd_t nxt_cmd;
  res_t      got;
  res_t      want;

  int  n_accepted   = 0;
  int  n_results    = 0;
  int  n_errors     = 0;
  int  n_full_seen  = 0;
  int  n_empty_seen = 0;
  int  src_gap      = 0;
  int  sink_gap     = 0;
  bit  idle_en      = 1'b1;
  bit  calm         = 1'b0;
  logic idle_ok;

  assign idle_ok = idle_en && !calm;

  always #5 clk_i = ~clk_i;

  positional_array_list_engine_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // position, value
    .s_axis_tuser  (s_axis_tuser),   // kind
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // index, data, count
    .m_axis_tuser  (m_axis_tuser),   // status
    .m_axis_tlast  (m_axis_tlast)
  );

  function automatic array_list_t power_on_list();
    array_list_t lst;
    logic [VAL_W-1:0] seed_vals[10];
    seed_vals = '{32'd7, 32'd21, 32'd18, 32'd45, 32'd93, 32'd3, 32'd11, 32'd1,
                  32'd99, 32'd17};
    lst = '0;
    for (int i = 0; i < 10 && i < CAPACITY; i++) begin
      lst.slot[i] = seed_vals[i];
      lst.fill    = lst.fill + 1'b1;
    end
    return lst;
  endfunction

  // applies one command to the list and returns the result transactions it causes
  function automatic void apply_list_cmd(ref array_list_t lst, input list_cmd_t c,
                                         ref res_t outs[$]);
    status_e st;
    res_t    r;
    int      n;
    int      p;
    int      i;
    outs.delete();
    st = ST_OK;
    r  = '0;
    n  = int'(lst.fill);
    p  = int'(c.pos);
    case (c.kind)
      KIND_INSERT: begin
        // full is checked ahead of the position
        if (n >= CAPACITY) begin
          st = ST_FULL;
        end else if (p > n) begin
          st = ST_INVALID;
        end else begin
          for (i = n; i > p; i--) lst.slot[i] = lst.slot[i-1];
          lst.slot[p] = c.value;
          lst.fill    = lst.fill + 1'b1;
        end
      end
      KIND_UPDATE: begin
        if (p < n) lst.slot[p] = c.value;
        else st = ST_INVALID;
      end
      KIND_DELETE: begin
        if (p < n) begin
          for (i = p; i + 1 < n; i++) lst.slot[i] = lst.slot[i+1];
          lst.fill       = lst.fill - 1'b1;
          lst.slot[n-1] = '0;
        end else begin
          st = ST_INVALID;
        end
      end
      KIND_FIND: begin
        st = ST_NOTFOUND;
        for (i = 0; i < n; i++) begin
          if (st == ST_NOTFOUND && lst.slot[i] == c.value) begin
            st      = ST_OK;
            r.index = OIDX_W'(i);
          end
        end
      end
      KIND_DISPLAY: begin
        if (n == 0) begin
          st = ST_EMPTY;
        end else begin
          for (i = 0; i < n; i++) begin
            r.status = ST_OK;
            r.index  = OIDX_W'(i);
            r.data   = lst.slot[i];
            r.count  = OCNT_W'(lst.fill);
            r.last   = (i + 1 == n);
            outs.push_back(r);
          end
          return;
        end
      end
      default: st = ST_INVALID;
    endcase
    r.status = st;
    r.count  = OCNT_W'(lst.fill);
    r.last   = 1'b1;
    outs.push_back(r);
  endfunction

  task automatic queue_cmd(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] p,
                           input logic [VAL_W-1:0] v);
    list_cmd_t c;
    c.kind  = k;
    c.pos   = p;
    c.value = v;
    cmd_backlog.push_back(c);
    // planning copy tracks the list so positions and keys can be aimed
    apply_list_cmd(plan_list, c, plan_scratch);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return VAL_W'($urandom_range(0, 20));
    if (r < 6) begin
      case ($urandom_range(0, 3))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return '0;
        default: return VAL_NEG1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] pick_pos(input logic [KIND_W-1:0] k);
    int r;
    int n;
    r = $urandom_range(0, 9);
    n = int'(plan_list.fill);
    if (r == 0) return POS_W'($urandom_range(0, POS_TOP));
    if (r == 1) return POS_W'(n);
    if (k == KIND_INSERT) return POS_W'($urandom_range(0, n));
    return (n == 0) ? '0 : POS_W'($urandom_range(0, n - 1));
  endfunction

  // command driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      src_gap = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        acc_cmd.kind  = s_axis_tuser;
        acc_cmd.pos   = s_axis_tdata[POS_W-1:0];
        acc_cmd.value = s_axis_tdata[POS_W +: VAL_W];
        apply_list_cmd(model_list, acc_cmd, step_results);
        foreach (step_results[k]) pending_results.push_back(step_results[k]);
        n_accepted++;
      end
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (idle_ok && $urandom_range(0, 7) == 0) begin
        src_gap = $urandom_range(0, 15);
        s_axis_tvalid <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        nxt_cmd = cmd_backlog.pop_front();
        s_axis_tdata  <= S_TDATA_W'({nxt_cmd.value, nxt_cmd.pos});
        s_axis_tuser  <= nxt_cmd.kind;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result monitor and backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = status_e'(m_axis_tuser);
        got.index  = m_axis_tdata[OIDX_W-1:0];
        got.data   = m_axis_tdata[OIDX_W +: VAL_W];
        got.count  = m_axis_tdata[OIDX_W+VAL_W +: OCNT_W];
        got.last   = m_axis_tlast;
        n_results++;
        if (got.status == ST_FULL) n_full_seen++;
        if (got.status == ST_EMPTY) n_empty_seen++;
        if (pending_results.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("[%0t] unexpected transaction: status=%0d index=%0d data=%h %s%0d last=%b",
                     $realtime, got.status, got.index, got.data, "count=",
                     got.count, got.last);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.index !== want.index ||
              got.data !== want.data || got.count !== want.count ||
              got.last !== want.last) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("[%0t] mismatch on transaction %0d:", $realtime, n_results);
              $display("  exp status=%0d index=%0d data=%h count=%0d last=%b",
                       want.status, want.index, want.data, want.count, want.last);
              $display("  got status=%0d index=%0d data=%h count=%0d last=%b",
                       got.status, got.index, got.data, got.count, got.last);
            end
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else if (idle_ok && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 15);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // quiet stretches with no idling on either side
  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) calm = ~calm;
  end

  initial begin : main_seq
    int total;
    int ph;
    int len;
    int mode;
    int roll;
    int n;
    logic [KIND_W-1:0] k;
    logic [VAL_W-1:0]  v;
    model_list = power_on_list();
    plan_list  = power_on_list();

    // directed: lookups on the initial list, edges of every command
    queue_cmd(KIND_DISPLAY, '0, '0);
    queue_cmd(KIND_FIND, '0, 32'd7);
    queue_cmd(KIND_FIND, '0, 32'd17);
    queue_cmd(KIND_FIND, '0, 32'd12345);
    queue_cmd(KIND_INSERT, '0, VAL_MIN);
    queue_cmd(KIND_INSERT, POS_W'(plan_list.fill), VAL_MAX);
    queue_cmd(KIND_INSERT, POS_W'(plan_list.fill + 1'b1), 32'd5);
    queue_cmd(KIND_INSERT, POS_TOP, 32'd6);
    queue_cmd(KIND_UPDATE, '0, VAL_NEG1);
    queue_cmd(KIND_UPDATE, POS_W'(plan_list.fill), 32'd8);
    queue_cmd(KIND_UPDATE, POS_TOP, 32'd9);
    queue_cmd(KIND_FIND, '0, VAL_MAX);
    queue_cmd(KIND_DELETE, '0, '0);
    queue_cmd(KIND_DELETE, POS_W'(plan_list.fill - 1'b1), '0);
    queue_cmd(KIND_DELETE, POS_W'(plan_list.fill), '0);
    for (int i = KIND_DISPLAY + 1; i <= KIND_TOP; i++)
      queue_cmd(KIND_W'(i), POS_W'($urandom_range(0, POS_TOP)), $urandom);
    // fill to capacity, then try once more
    while (plan_list.fill < CAPACITY)
      queue_cmd(KIND_INSERT, POS_W'($urandom_range(0, plan_list.fill)), pick_value());
    queue_cmd(KIND_INSERT, '0, 32'd1);
    queue_cmd(KIND_DISPLAY, '0, '0);

    // random phases alternate between growing, draining and mixed traffic
    ph = 0;
    while (cmd_backlog.size() < N_ITEMS) begin
      mode = ph % 3;
      len  = $urandom_range(25, 50);
      for (int j = 0; j < len && cmd_backlog.size() < N_ITEMS; j++) begin
        roll = $urandom_range(0, 99);
        case (mode)
          MODE_GROW:
            k = (roll < 55) ? KIND_INSERT : (roll < 65) ? KIND_UPDATE :
                (roll < 72) ? KIND_DELETE : (roll < 87) ? KIND_FIND :
                (roll < 95) ? KIND_DISPLAY : KIND_TOP;
          MODE_SHRINK:
            k = (roll < 10) ? KIND_INSERT : (roll < 20) ? KIND_UPDATE :
                (roll < 70) ? KIND_DELETE : (roll < 85) ? KIND_FIND :
                (roll < 95) ? KIND_DISPLAY : KIND_TOP;
          default:
            k = (roll < 25) ? KIND_INSERT : (roll < 40) ? KIND_UPDATE :
                (roll < 60) ? KIND_DELETE : (roll < 80) ? KIND_FIND :
                (roll < 95) ? KIND_DISPLAY : KIND_TOP;
        endcase
        if (k == KIND_TOP) k = KIND_W'($urandom_range(KIND_DISPLAY + 1, KIND_TOP));
        n = int'(plan_list.fill);
        // finds mostly aim at a value that is present
        if (k == KIND_FIND && n > 0 && $urandom_range(0, 9) < 6)
          v = plan_list.slot[$urandom_range(0, n - 1)];
        else
          v = pick_value();
        queue_cmd(k, pick_pos(k), v);
      end
      ph++;
    end
    total = cmd_backlog.size();

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    while (n_accepted + 40 < total) @(negedge clk_i);
    idle_en = 1'b0;
    while (n_accepted < total || pending_results.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYC) @(negedge clk_i);

    $display("covered %0d commands and %0d result transactions, %0d mismatches",
             total, n_results, n_errors);
    $display("full-list rejects seen: %0d, empty-list readouts seen: %0d",
             n_full_seen, n_empty_seen);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d results still outstanding", pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
